// ===== src/sorted_byte_list_top_macros.svh =====
// Assertion macros used by the sorted byte list top level.
`ifndef SORTED_BYTE_LIST_TOP_MACROS_SVH
`define SORTED_BYTE_LIST_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SLB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slb_pkg.sv =====
`timescale 1ns / 1ps

package slb_pkg;

  // Number of cells in the chain.
  localparam int unsigned Capacity = 32;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 8;
  localparam int unsigned RankW    = 5;
  localparam int unsigned CmdW     = 2;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 2'd0,
    CmdRemove = 2'd1,
    CmdClear  = 2'd2,
    CmdRead   = 2'd3
  } cmd_e;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic            ins_en;
    logic            rem_en;
    logic [KeyW-1:0] key;
  } cell_ctl_t;

  // Compare results that a cell reports back.
  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } cell_sts_t;

endpackage

// ===== src/slb_cell.sv =====
`timescale 1ns / 1ps

module slb_cell (
  input  logic                     clk_i,
  input  logic                     occ_i,
  input  slb_pkg::cell_ctl_t       ctl_i,
  input  logic                     left_le_i,
  input  logic [slb_pkg::KeyW-1:0] left_entry_i,
  input  logic [slb_pkg::KeyW-1:0] right_entry_i,
  output logic [slb_pkg::KeyW-1:0] entry_o,
  output slb_pkg::cell_sts_t       sts_o
);

  logic [slb_pkg::KeyW-1:0] entry_q;
  logic [slb_pkg::KeyW-1:0] entry_d;

  // Compare the broadcast key with the entry held here.
  always_comb begin
    sts_o.le = occ_i && (entry_q <= ctl_i.key);
    sts_o.lt = occ_i && (entry_q < ctl_i.key);
    sts_o.eq = occ_i && (entry_q == ctl_i.key);
  end

  // An insert shifts entries right of the slot up by one; a remove pulls them down.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en && !sts_o.le) begin
      entry_d = left_le_i ? ctl_i.key : left_entry_i;
    end else if (ctl_i.rem_en && !sts_o.lt) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/sorted_byte_list_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Fields (tdata, lowest bit first)
// s_axis    in         command[1:0], key[9:2], rank[14:10], zero pad to 16 bits
// m_axis    out        ok[0], value[8:1], count[14:9], zero pad to 16 bits
//
// For each command the cells compare and shift in parallel.
// The result is held in an output register; a new command is taken whenever that
// register is empty or is being emptied in the same cycle.
// After reset the list is empty; entries themselves are not reset.
// A stall on m_axis holds the result and stops s_axis until it is taken.

`include "sorted_byte_list_top_macros.svh"

module sorted_byte_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // command, key, rank, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // ok, value, count, pad
);

  localparam int unsigned N = slb_pkg::Capacity;

  logic [slb_pkg::CountW-1:0] count_q;
  logic [slb_pkg::CountW-1:0] count_d;
  logic                       out_valid_q;
  logic [15:0]                out_data_q;
  logic [15:0]                out_data_d;

  slb_pkg::cmd_e               cmd;
  logic [slb_pkg::KeyW-1:0]    key;
  logic [slb_pkg::RankW-1:0]   rank;
  logic                        accept;
  logic                        full;
  logic                        found;
  logic                        ok;
  logic [slb_pkg::KeyW-1:0]    value;
  slb_pkg::cell_ctl_t          ctl;

  logic [slb_pkg::KeyW-1:0]    entries [N];
  slb_pkg::cell_sts_t          sts     [N];
  logic [N-1:0]                eq_vec;

  // Unpack the incoming transaction.
  assign cmd  = slb_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign key  = s_axis_tdata[9:2];
  assign rank = s_axis_tdata[14:10];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count_q >= slb_pkg::CountW'(N));
  assign found = |eq_vec;

  // Control broadcast to the chain.
  always_comb begin
    ctl.key    = key;
    ctl.ins_en = accept && (cmd == slb_pkg::CmdInsert) && !full;
    ctl.rem_en = accept && (cmd == slb_pkg::CmdRemove) && found;
  end

  // The chain of cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                     left_le;
    logic [slb_pkg::KeyW-1:0] left_entry;
    logic [slb_pkg::KeyW-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = key;
    end else begin : g_mid
      assign left_le    = sts[i-1].le;
      assign left_entry = entries[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    slb_cell u_cell (
      .clk_i        (clk_i),
      .occ_i        (slb_pkg::CountW'(i) < count_q),
      .ctl_i        (ctl),
      .left_le_i    (left_le),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entries[i]),
      .sts_o        (sts[i])
    );

    assign eq_vec[i] = sts[i].eq;
  end

  // Result and next count for the command.
  always_comb begin
    ok      = 1'b0;
    value   = '0;
    count_d = count_q;
    unique case (cmd)
      slb_pkg::CmdInsert: begin
        ok = !full;
        if (!full) begin
          count_d = count_q + 1'b1;
        end
      end
      slb_pkg::CmdRemove: begin
        ok = found;
        if (found) begin
          value   = key;
          count_d = count_q - 1'b1;
        end
      end
      slb_pkg::CmdClear: begin
        ok      = 1'b1;
        count_d = '0;
      end
      slb_pkg::CmdRead: begin
        if (slb_pkg::CountW'(rank) < count_q) begin
          ok    = 1'b1;
          value = entries[rank];
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    out_data_d = {1'b0, count_d, value, ok};
  end

  // Count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks on the list bookkeeping.
  `SLB_ASSERT_ALWAYS(a_count_bound, count_q <= slb_pkg::CountW'(N), "count beyond capacity")
  `SLB_ASSERT_NEXT(a_clear_empties, accept && cmd == slb_pkg::CmdClear, count_q == '0, "clear left entries")
  `SLB_ASSERT_NEXT(a_remove_dec, ctl.rem_en, count_q == $past(count_q) - 1'b1, "remove did not shrink list")
  `SLB_ASSERT_NEXT(a_result_count, accept, out_data_q[14:9] == count_q, "reported count differs from list")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // One result transaction, in field order from the lowest bit of tdata up.
  typedef struct packed {
    logic       ok;
    logic [7:0] value;
    logic [5:0] count;
  } result_t;

  // One row of the directed script; reps repeats the same command.
  typedef struct packed {
    slb_pkg::cmd_e op;
    logic [7:0]    key;
    logic [4:0]    rank;
    logic [5:0]    reps;
    logic          typed;
    result_t       want;
  } script_row_t;

  localparam int StallLimit = 2000;
  localparam int ItemsPerPhase = 333;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Sorted copy of the list contents as the block should hold them.
  logic [7:0] held_keys[$];
  result_t    expected_results[$];
  int         mismatches = 0;
  int         src_idle_pct = 0;
  int         sink_idle_pct = 0;
  bit         filling = 1'b1;

  // Directed script: typed expectations where they are obvious, otherwise predicted.
  script_row_t script [23] = '{
    '{slb_pkg::CmdRead,   8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0}},
    '{slb_pkg::CmdRemove, 8'h00, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd0}},
    '{slb_pkg::CmdClear,  8'h00, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd0}},
    '{slb_pkg::CmdRead,   8'h00, 5'd31, 6'd1,  1'b1, '{1'b0, 8'h00, 6'd0}},
    '{slb_pkg::CmdInsert, 8'hFF, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd1}},
    '{slb_pkg::CmdInsert, 8'h00, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd2}},
    '{slb_pkg::CmdInsert, 8'h00, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd3}},
    '{slb_pkg::CmdRead,   8'h00, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdRead,   8'h00, 5'd2,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdInsert, 8'h80, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdRemove, 8'hFF, 5'd0,  6'd1,  1'b1, '{1'b1, 8'hFF, 6'd3}},
    '{slb_pkg::CmdRemove, 8'h7F, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd3}},
    '{slb_pkg::CmdRead,   8'h00, 5'd3,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd3}},
    '{slb_pkg::CmdInsert, 8'hAA, 5'd0,  6'd29, 1'b0, '0},
    '{slb_pkg::CmdInsert, 8'h55, 5'd0,  6'd1,  1'b1, '{1'b0, 8'h00, 6'd32}},
    '{slb_pkg::CmdRead,   8'h00, 5'd31, 6'd1,  1'b0, '0},
    '{slb_pkg::CmdRead,   8'h00, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdRemove, 8'hAA, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdInsert, 8'h01, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdRemove, 8'h01, 5'd0,  6'd1,  1'b0, '0},
    '{slb_pkg::CmdClear,  8'h00, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd0}},
    '{slb_pkg::CmdClear,  8'h00, 5'd0,  6'd1,  1'b1, '{1'b1, 8'h00, 6'd0}},
    '{slb_pkg::CmdInsert, 8'h7F, 5'd17, 6'd1,  1'b0, '0}
  };

  sorted_byte_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Applies one command to the sorted list and returns the result it gives.
  function automatic result_t apply_command(slb_pkg::cmd_e op, logic [7:0] key,
                                            logic [4:0] rank);
    int      pos;
    result_t res;
    res = '0;
    unique case (op)
      slb_pkg::CmdInsert: begin
        if (held_keys.size() < slb_pkg::Capacity) begin
          // A duplicate goes after the equal keys already held.
          pos = 0;
          while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
          held_keys.insert(pos, key);
          res.ok = 1'b1;
        end
      end
      slb_pkg::CmdRemove: begin
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key) pos++;
        if (pos < held_keys.size() && held_keys[pos] == key) begin
          held_keys.delete(pos);
          res.ok = 1'b1;
          res.value = key;
        end
      end
      slb_pkg::CmdClear: begin
        held_keys.delete();
        res.ok = 1'b1;
      end
      default: begin
        if (rank < held_keys.size()) begin
          res.ok = 1'b1;
          res.value = held_keys[rank];
        end
      end
    endcase
    res.count = 6'(held_keys.size());
    return res;
  endfunction

  task automatic log_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected ok=%0d value=%0d count=%0d, got ok=%0d value=%0d count=%0d",
               $time, what, want.ok, want.value, want.count, got.ok, got.value, got.count);
    end
  endtask

  // Offers one command and records its expected result once the transaction is taken.
  task automatic send_command(slb_pkg::cmd_e op, logic [7:0] key, logic [4:0] rank,
                              logic typed, result_t want);
    result_t predicted;
    // The sender stays idle in each cycle with the given probability.
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rank, key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_command(op, key, rank);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Random command, alternating between filling the list up and draining it.
  task automatic pick_command(output slb_pkg::cmd_e op, output logic [7:0] key,
                              output logic [4:0] rank);
    int roll;
    int held;
    held = held_keys.size();
    if (held == slb_pkg::Capacity && $urandom_range(3) == 0) filling = 1'b0;
    else if (held == 0) filling = 1'b1;
    else if ($urandom_range(49) == 0) filling = !filling;
    roll = $urandom_range(199);
    key  = 8'($urandom_range(255));
    rank = 5'($urandom_range(31));
    if (roll == 0) begin
      op = slb_pkg::CmdClear;
    end else if (roll < 36) begin
      op = slb_pkg::CmdRead;
      if (held > 0 && $urandom_range(9) < 7) rank = 5'($urandom_range(held - 1));
    end else if ((roll < 156) == filling) begin
      op = slb_pkg::CmdInsert;
      if (held > 0 && $urandom_range(3) == 0) key = held_keys[$urandom_range(held - 1)];
    end else begin
      op = slb_pkg::CmdRemove;
      if (held > 0 && $urandom_range(9) < 7) key = held_keys[$urandom_range(held - 1)];
    end
  endtask

  // Compare each result transaction with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok    = m_axis_tdata[0];
      got.value = m_axis_tdata[8:1];
      got.count = m_axis_tdata[14:9];
      if (expected_results.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok || got.value !== want.value || got.count !== want.count) begin
          log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Ends the run if no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    slb_pkg::cmd_e op;
    logic [7:0]    key;
    logic [4:0]    rank;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script under the first idling pattern.
    src_idle_pct  = 18;
    sink_idle_pct = 73;
    foreach (script[i]) begin
      repeat (script[i].reps) begin
        send_command(script[i].op, script[i].key, script[i].rank, script[i].typed,
                     script[i].want);
      end
    end

    // Random phases: slow receiver, then slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 73 : 0;
      sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 18 : 0;
      // Hold the sender back until every outstanding result has been taken.
      s_axis_tvalid <= 1'b0;
      wait_drained();
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pick_command(op, key, rank);
        send_command(op, key, rank, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/slb_pkg.sv
src/slb_cell.sv
src/sorted_byte_list_top.sv
verif/testbench.sv
